// ===== sv/spmq_pkg.sv =====
package spmq_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int TOKEN_W   = 16;
  localparam int PRI_W     = 3;
  localparam int STATUS_W  = 2;
  localparam int OCC_W     = 5;

  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  localparam logic [STATUS_W-1:0] ST_ENQUEUED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_SERVED   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd3;

  typedef struct packed {
    logic [TOKEN_W-1:0] token;
    logic [PRI_W-1:0]   pri;
  } entry_t;

  // broadcast to every cell; at most one of enq/deq is set
  typedef struct packed {
    logic   enq;
    logic   deq;
    entry_t word;
  } cmd_t;

endpackage

// ===== sv/spmq_cell.sv =====
module spmq_cell
  import spmq_pkg::*;
(
  input  logic   clk,
  input  cmd_t   cmd,
  input  logic   valid,
  input  logic   left_keep,
  input  entry_t left_entry,
  input  entry_t right_entry,
  output entry_t entry,
  output logic   keep
);

  entry_t entry_next;

  // holds its place on insert when it ranks ahead of or ties the new word
  assign keep = valid && (entry.pri <= cmd.word.pri);

  always_comb begin
    entry_next = entry;
    if (cmd.enq) begin
      if (!keep) begin
        entry_next = left_keep ? cmd.word : left_entry;
      end
    end else if (cmd.deq) begin
      entry_next = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

// ===== sv/stable_min_priority_queue.sv =====
// Stable min-first priority queue of (token, priority) pairs.
// Command channel: a word is taken on a rising edge with start high and
// busy low; op selects enqueue (0) or dequeue (1). busy is high only while
// rst is held and the cycle after.
// Result channel: one word per command, shown on status, served_token,
// served_priority and occupancy for exactly one cycle while done is high,
// in the cycle after the command is taken. The receiver cannot stall.
// Throughput 1 command per cycle, no gaps.
// Entries sit sorted by priority, then arrival, in a row of DEPTH cells;
// cell 0 is the head. An enqueue shifts the tail of the row right by one
// and drops the word into the gap; a dequeue takes cell 0 and shifts the
// row left. Each cell sees only its neighbors and the broadcast command, so
// every cell updates in the same cycle regardless of DEPTH.
// Status: 0 enqueued, 1 full and dropped, 2 served, 3 empty; token and
// priority read zero unless served. Reset empties the queue; cell contents
// are not cleared.
module stable_min_priority_queue
  import spmq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic                op,
  input  logic [TOKEN_W-1:0]  token_in,
  input  logic [PRI_W-1:0]    priority_in,
  output logic                done,
  output logic [STATUS_W-1:0] status,
  output logic [TOKEN_W-1:0]  served_token,
  output logic [PRI_W-1:0]    served_priority,
  output logic [OCC_W-1:0]    occupancy
);

  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic          take;
  logic          full;
  logic          empty;
  cmd_t          cmd;
  logic [STATUS_W-1:0] status_next;

  entry_t cells [DEPTH];
  logic   keeps [DEPTH];

  assign take  = start && !busy;
  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);

  assign cmd.enq  = take && (op == OP_ENQ) && !full;
  assign cmd.deq  = take && (op == OP_DEQ) && !empty;
  assign cmd.word = '{token: token_in, pri: priority_in};

  always_comb begin
    count_next = count;
    if (cmd.enq) begin
      count_next = count + CW'(1);
    end else if (cmd.deq) begin
      count_next = count - CW'(1);
    end
    if (op == OP_ENQ) begin
      status_next = full ? ST_FULL : ST_ENQUEUED;
    end else begin
      status_next = empty ? ST_EMPTY : ST_SERVED;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    spmq_cell u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .valid       (CW'(i) < count),
      .left_keep   ((i == 0) ? 1'b1 : keeps[(i == 0) ? 0 : i - 1]),
      .left_entry  (cells[(i == 0) ? 0 : i - 1]),
      .right_entry (cells[(i == DEPTH - 1) ? i : i + 1]),
      .entry       (cells[i]),
      .keep        (keeps[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      busy  <= 1'b1;
      done  <= 1'b0;
    end else begin
      count <= count_next;
      busy  <= 1'b0;
      done  <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      status          <= status_next;
      served_token    <= cmd.deq ? cells[0].token : '0;
      served_priority <= cmd.deq ? cells[0].pri : '0;
      occupancy       <= OCC_W'(count_next);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("count above depth");

  a_head_sorted: assert property (@(posedge clk) disable iff (rst)
    (count >= CW'(2)) |-> (cells[0].pri <= cells[1].pri))
    else $error("head out of order");

  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    $past(take) |-> done)
    else $error("result word missing");

  a_zero_payload: assert property (@(posedge clk) disable iff (rst)
    (done && (status != ST_SERVED)) |-> (served_token == '0 && served_priority == '0))
    else $error("payload not zero");

  a_enq_occ: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_ENQUEUED) |-> (count != '0))
    else $error("enqueue left queue empty");

endmodule
